### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and disabled under reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and constants of the indexed list with insert and remove.
// ----------------------------------------------------------------------------
package ilir_pkg;

    // Default sizing
    localparam int CAPACITY_DEF = 64;
    localparam int ELEM_W_DEF   = 32;

    // Fixed field widths of the stream payload
    localparam int OPCODE_W = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // Operation codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_GET    = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_PUSH   = 3'd3,
        OP_POP    = 3'd4
    } t_opcode;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // open a gap at the target index and load the new word
        logic rem;   // close the gap at the target index
    } t_cell_ctl;

endpackage

### rtl/ilir_cell.sv
// ----------------------------------------------------------------------------
// ilir_cell
// One list slot: holds a word, shifts up or down with its neighbors, and
// drives its word onto the read bus when addressed.
// ----------------------------------------------------------------------------
module ilir_cell #(
    parameter int CELL_IDX = 0,
    parameter int ELEM_W   = 32,
    parameter int AT_W     = 7
) (
    input  logic                 i_clk,
    input  ilir_pkg::t_cell_ctl  i_ctl,
    input  logic [AT_W-1:0]      i_at,
    input  logic [ELEM_W-1:0]    i_value,
    input  logic [ELEM_W-1:0]    i_left,     // word of the slot below
    input  logic [ELEM_W-1:0]    i_right,    // word of the slot above
    output logic [ELEM_W-1:0]    o_entry,
    output logic [ELEM_W-1:0]    o_read      // own word if addressed, else zero
);
    import ilir_pkg::*;

    localparam logic [AT_W-1:0] MY_IDX = AT_W'(CELL_IDX);

    logic [ELEM_W-1:0] r_entry;
    logic [ELEM_W-1:0] n_entry;
    logic              w_at_me;
    logic              w_above;

    assign w_at_me = (i_at == MY_IDX);
    assign w_above = (MY_IDX > i_at);

    // Next word: load, shift up from below, or shift down from above
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (w_at_me) begin
                n_entry = i_value;
            end else if (w_above) begin
                n_entry = i_left;
            end
        end else if (i_ctl.rem) begin
            if (w_at_me || w_above) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_read  = w_at_me ? r_entry : '0;

endmodule

### rtl/indexed_list_insert_remove_top.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_top
// Ordered list of up to CAPACITY words held in a chain of shift cells.
// ----------------------------------------------------------------------------
// Each request (get, insert, remove, push, pop) is taken into a command
// register and executed from there once the output register is free or
// draining: on insert or remove the cells at and above the target index
// shift together, the addressed cell drives the read bus, and the result
// lands in an output register. A new request is taken every cycle while
// results are drained, so throughput is one item per clock. The result
// passes through the command register and then the output register. A
// result that is held back by the receiver keeps the next request in the
// command register and stalls the input. Out-of-range requests and inserts
// into a full list are rejected with a status code and change nothing.
module indexed_list_insert_remove_top #(
    parameter int CAPACITY = ilir_pkg::CAPACITY_DEF,
    parameter int ELEM_W   = ilir_pkg::ELEM_W_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] opcode, [9:3] position, [41:10] item_value, [47:42] zero
    input  logic [ilir_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] element_out, [33:32] status, [40:34] entry_count, [47:41] zero
    output logic [ilir_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import ilir_pkg::*;
    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AT_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int EXT_W = (ELEM_W > VALUE_W) ? ELEM_W : VALUE_W;
    localparam logic [AT_W-1:0] CAP_AT = AT_W'(CAPACITY);

    // Command register
    logic                 r_cmd_valid;
    logic [OPCODE_W-1:0]  r_op;
    logic [POS_W-1:0]     r_pos;
    logic [ELEM_W-1:0]    r_value;
    logic [EXT_W-1:0]     w_in_ext;

    // List state and output register
    logic [CNT_W-1:0]     r_count;
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_elem;
    logic [STATUS_W-1:0]  r_out_status;
    logic [COUNT_W-1:0]   r_out_count;

    logic                 w_exec;
    logic                 w_accept;

    // Execution decode
    t_cell_ctl            w_ctl;
    logic [AT_W-1:0]      w_at;
    logic [AT_W-1:0]      w_cnt;
    logic [AT_W-1:0]      w_pos;
    logic                 w_read;
    logic [STATUS_W-1:0]  w_status;
    logic [CNT_W-1:0]     n_count;
    logic [ELEM_W-1:0]    w_bus;
    logic [EXT_W-1:0]     w_elem_ext;
    logic [AT_W-1:0]      w_cnt_next;

    // Cell chain
    logic [ELEM_W-1:0]    w_entry [CAPACITY];
    logic [ELEM_W-1:0]    w_rd    [CAPACITY];

    // Handshake: execute when the output register is free or draining
    assign w_exec        = r_cmd_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_cmd_valid || w_exec;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_ext      = EXT_W'(s_axis_tdata[41:10]);

    // Command capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (w_accept) begin
            r_cmd_valid <= 1'b1;
        end else if (w_exec) begin
            r_cmd_valid <= 1'b0;
        end
        if (w_accept) begin
            r_op    <= s_axis_tdata[2:0];
            r_pos   <= s_axis_tdata[9:3];
            r_value <= w_in_ext[ELEM_W-1:0];
        end
    end

    // Request decode against the current fill count
    always_comb begin
        w_cnt    = AT_W'(r_count);
        w_pos    = AT_W'(r_pos);
        w_ctl    = '0;
        w_at     = w_pos;
        w_read   = 1'b0;
        w_status = ST_RANGE;
        n_count  = r_count;
        case (t_opcode'(r_op))
            OP_GET: begin
                if (w_pos < w_cnt) begin
                    w_read   = 1'b1;
                    w_status = ST_OK;
                end
            end
            OP_INSERT, OP_PUSH: begin
                if (t_opcode'(r_op) == OP_PUSH) begin
                    w_at = w_cnt;
                end
                if (w_at > w_cnt) begin
                    w_status = ST_RANGE;
                end else if (w_cnt == CAP_AT) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.ins = 1'b1;
                    w_status  = ST_OK;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (w_pos < w_cnt) begin
                    w_ctl.rem = 1'b1;
                    w_read    = 1'b1;
                    w_status  = ST_OK;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            OP_POP: begin
                w_at = w_cnt - AT_W'(1);
                if (r_count != '0) begin
                    w_ctl.rem = 1'b1;
                    w_read    = 1'b1;
                    w_status  = ST_OK;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
        if (!w_exec) begin
            w_ctl   = '0;
            n_count = r_count;
        end
    end

    // Row of cells
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [ELEM_W-1:0] w_left;
        logic [ELEM_W-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = w_entry[k];
        end else begin : g_mid_lo
            assign w_left = w_entry[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[k];
        end else begin : g_mid_hi
            assign w_right = w_entry[k+1];
        end
        ilir_cell #(
            .CELL_IDX (k),
            .ELEM_W   (ELEM_W),
            .AT_W     (AT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_at    (w_at),
            .i_value (r_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[k]),
            .o_read  (w_rd[k])
        );
    end

    // Read bus: only the addressed cell drives a nonzero word
    always_comb begin
        w_bus = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_bus = w_bus | w_rd[k];
        end
        w_elem_ext = w_read ? EXT_W'(w_bus) : '0;
        w_cnt_next = AT_W'(n_count);
    end

    // Fill count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_exec) begin
            r_out_elem   <= w_elem_ext[VALUE_W-1:0];
            r_out_status <= w_status;
            r_out_count  <= w_cnt_next[COUNT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_count, r_out_status, r_out_elem};

    // Checks
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n,
        AT_W'(r_count) <= CAP_AT, "fill count over capacity")
    `ASSERT_IMPLIES(a_full_status, i_clk, i_rst_n,
        r_out_valid && r_out_status == ST_FULL, AT_W'(r_count) == CAP_AT,
        "full status with room left")
    `ASSERT_NEXT(a_exec_result, i_clk, i_rst_n,
        w_exec, r_out_valid, "executed request left no result")

endmodule
